>>> rtl/core/dhf_pkg.sv
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared constants, types and helpers of the depth hole-fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package dhf_pkg;

  localparam int MAX_KERNEL  = 5;
  localparam int MAX_WIDTH   = 2048;
  localparam int PIXEL_BITS  = 16;

  localparam int NUM_WEIGHTS = MAX_KERNEL * MAX_KERNEL;
  localparam int WT_W        = 17;                    // Q1.16 weight
  localparam int WIDX_W      = 5;                     // weight_index field
  localparam int KS_W        = 3;                     // kernel_size field
  localparam int WCFG_W      = 12;                    // image_width field
  localparam int ROW_W       = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(MAX_KERNEL);
  localparam int KK_W        = $clog2(NUM_WEIGHTS + 1);
  localparam int KIDX_W      = $clog2(NUM_WEIGHTS);
  localparam int ADDR_W      = $clog2(MAX_KERNEL * MAX_WIDTH);
  localparam int PROD_W      = PIXEL_BITS + WT_W;
  localparam int SUM_W       = PROD_W + $clog2(NUM_WEIGHTS);
  localparam int MISS_W      = WT_W + $clog2(NUM_WEIGHTS);
  localparam int DCNT_W      = $clog2(SUM_W + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 17;
  localparam int ONE_Q16     = 65536;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_LIMIT  = 2'd3
  } dhf_reg_t;

  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_WEIGHT = 1'b1
  } dhf_op_t;

  // effective configuration after clamping
  typedef struct packed {
    logic [WCFG_W-1:0] width;
    logic [ROW_W-1:0]  height;
    logic [KS_W-1:0]   span;
    logic [KS_W-1:0]   half;
    logic [KK_W-1:0]   kk;
    logic [WT_W-1:0]   limit;
  } dhf_cfg_t;

  typedef struct packed {
    dhf_op_t               op;
    logic [PIXEL_BITS-1:0] pix;
    logic [WIDX_W-1:0]     widx;
    logic [WT_W-1:0]       wval;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [SLOT_W-1:0]     slot;
    logic                  emit;
    logic                  last;
  } dhf_job_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(MAX_KERNEL - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dhf_fifo.sv
// ----------------------------------------------------------------------------
// dhf_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dhf_fifo (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic push,
  input  dhf_pkg::dhf_job_t  push_job,
  output logic               full,
  input  wire                logic pop,
  output dhf_pkg::dhf_job_t  head_job,
  output logic               not_empty
);
  import dhf_pkg::*;

  dhf_job_t            ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = ent_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= ptr_inc(wp_r);
      if (do_pop)  rp_r <= ptr_inc(rp_r);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dhf_front.sv
// ----------------------------------------------------------------------------
// dhf_front
// Accepts words, tracks the raster position and tags each pixel job.
// ----------------------------------------------------------------------------
`default_nettype none

module dhf_front (
  input  wire                    logic clk,
  input  wire                    logic rst_n,
  input  dhf_pkg::dhf_cfg_t      cfg,
  input  wire                    logic in_valid,
  output logic                   in_ready,
  input  wire                    logic in_op,
  input  wire [dhf_pkg::PIXEL_BITS-1:0] in_pix,
  input  wire [dhf_pkg::WIDX_W-1:0]     in_widx,
  input  wire [dhf_pkg::WT_W-1:0]       in_wval,
  input  wire                    logic q_full,
  output logic                   q_push,
  output dhf_pkg::dhf_job_t      q_job
);
  import dhf_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [WCFG_W-1:0] c_pre, c_post;
  logic [ROW_W:0]    r_pre, r_post;
  logic [SLOT_W-1:0] s_pre, s_post;
  logic              is_pixel;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign is_pixel = (dhf_op_t'(in_op) == OP_PIXEL);

  always_comb begin
    // wrap first in case the frame size shrank
    c_pre = {1'b0, col_r};
    r_pre = {1'b0, row_r};
    s_pre = slot_r;
    if (c_pre >= cfg.width) begin
      c_pre = '0;
      r_pre = r_pre + 1'b1;
      s_pre = slot_inc(s_pre);
    end
    if (r_pre >= {1'b0, cfg.height}) begin
      r_pre = '0;
      s_pre = '0;
    end
    c_post = c_pre + 1'b1;
    r_post = r_pre;
    s_post = s_pre;
    if (c_post >= cfg.width) begin
      c_post = '0;
      r_post = r_pre + 1'b1;
      s_post = slot_inc(s_pre);
      if (r_post >= {1'b0, cfg.height}) begin
        r_post = '0;
        s_post = '0;
      end
    end
    col_nxt  = c_post[COL_W-1:0];
    row_nxt  = r_post[ROW_W-1:0];
    slot_nxt = s_post;
  end

  always_comb begin
    q_job.op   = dhf_op_t'(in_op);
    q_job.pix  = in_pix;
    q_job.widx = in_widx;
    q_job.wval = in_wval;
    q_job.col  = c_pre[COL_W-1:0];
    q_job.row  = r_pre[ROW_W-1:0];
    q_job.slot = s_pre;
    q_job.emit = (c_pre >= WCFG_W'(cfg.span)) && (r_pre >= (ROW_W+1)'(cfg.span));
    q_job.last = (c_pre == cfg.width - 1'b1) && (r_pre[ROW_W-1:0] == cfg.height - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (q_push && is_pixel) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dhf_back.sv
// ----------------------------------------------------------------------------
// dhf_back
// Executes jobs: line store and weight writes, window sweep, fill divide.
// ----------------------------------------------------------------------------
`default_nettype none

module dhf_back (
  input  wire                    logic clk,
  input  wire                    logic rst_n,
  input  dhf_pkg::dhf_cfg_t      cfg,
  input  dhf_pkg::dhf_job_t      job,
  input  wire                    logic job_valid,
  output logic                   job_pop,
  input  wire                    logic out_ready,
  output logic                   out_valid,
  output logic [dhf_pkg::PIXEL_BITS-1:0] out_value,
  output logic [dhf_pkg::COL_W-1:0]      out_col,
  output logic [dhf_pkg::ROW_W-1:0]      out_row,
  output logic                   out_filled,
  output logic                   out_last
);
  import dhf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_FIN   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r;

  // line store and kernel weights
  logic [PIXEL_BITS-1:0] line_mem [MAX_KERNEL * MAX_WIDTH];
  logic [WT_W-1:0]       kw_r [NUM_WEIGHTS];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic                  wr_en, rd_en, wt_en;

  // sweep control
  logic                  issue_r;
  logic [KS_W-1:0]       dx_r;
  logic [SLOT_W-1:0]     slot_rd_r, slot_start;
  logic [COL_W-1:0]      col_rd_r, col_start_r;
  logic [KK_W-1:0]       kidx_rd_r;
  logic                  s1_v_r, s2_v_r;
  logic [KK_W-1:0]       s1_idx_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SUM_W-1:0]      sum_r;
  logic [MISS_W-1:0]     miss_r;
  logic [PIXEL_BITS-1:0] centre_r;
  logic [WT_W-1:0]       s1_wt;

  // divider
  logic [SUM_W-1:0]      dvd_r;
  logic [WT_W-1:0]       rem_r, divisor_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [WT_W:0]         trial;
  logic                  trial_ge;

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign wr_en     = job_pop && (job.op == OP_PIXEL);
  assign wt_en     = job_pop && (job.op == OP_WEIGHT) && (job.widx < WIDX_W'(NUM_WEIGHTS));
  assign wr_addr   = ADDR_W'(job.slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(job.col);
  assign rd_en     = (state_r == S_SWEEP) && issue_r;
  assign rd_addr   = ADDR_W'(slot_rd_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_rd_r);
  assign s1_wt     = kw_r[s1_idx_r[KIDX_W-1:0]];
  assign out_valid = (state_r == S_OUT);

  // oldest window row: current slot minus span, modulo the row count
  always_comb begin
    logic [SLOT_W:0] t;
    t = {1'b0, job.slot} + (SLOT_W+1)'(MAX_KERNEL) - (SLOT_W+1)'(cfg.span);
    if (t >= (SLOT_W+1)'(MAX_KERNEL)) t = t - (SLOT_W+1)'(MAX_KERNEL);
    slot_start = t[SLOT_W-1:0];
  end

  assign trial    = {rem_r, dvd_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= job.pix;
    if (rd_en) rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wt_en) kw_r[job.widx[KIDX_W-1:0]] <= job.wval;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s1_idx_r <= kidx_rd_r;
    prod_r   <= rd_data_r * s1_wt;
    if (job_pop) begin
      col_start_r <= job.col - COL_W'(cfg.span);
      col_rd_r    <= job.col - COL_W'(cfg.span);
      slot_rd_r   <= slot_start;
      dx_r        <= '0;
      kidx_rd_r   <= '0;
      sum_r       <= '0;
      miss_r      <= '0;
      centre_r    <= '0;
      out_col     <= job.col - COL_W'(cfg.half);
      out_row     <= job.row - ROW_W'(cfg.half);
      out_last    <= job.last;
    end else begin
      if (rd_en) begin
        kidx_rd_r <= kidx_rd_r + 1'b1;
        if (dx_r == cfg.span) begin
          dx_r      <= '0;
          col_rd_r  <= col_start_r;
          slot_rd_r <= slot_inc(slot_rd_r);
        end else begin
          dx_r     <= dx_r + 1'b1;
          col_rd_r <= col_rd_r + 1'b1;
        end
      end
      if (s1_v_r && rd_data_r == '0) miss_r <= miss_r + MISS_W'(s1_wt);
      if (s1_v_r && s1_idx_r == (cfg.kk >> 1)) centre_r <= rd_data_r;
      if (s2_v_r) sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (state_r == S_FIN) begin
      dvd_r     <= sum_r;
      rem_r     <= '0;
      dcnt_r    <= '0;
      divisor_r <= WT_W'(MISS_W'(ONE_Q16) - miss_r);
      out_value <= centre_r;
      out_filled <= 1'b0;
    end else if (state_r == S_DIV) begin
      if (dcnt_r == DCNT_W'(SUM_W)) begin
        out_value  <= (|dvd_r[SUM_W-1:PIXEL_BITS]) ? '1 : dvd_r[PIXEL_BITS-1:0];
        out_filled <= 1'b1;
      end else begin
        // restoring divide, one quotient bit a cycle
        rem_r  <= trial_ge ? WT_W'(trial - {1'b0, divisor_r}) : trial[WT_W-1:0];
        dvd_r  <= {dvd_r[SUM_W-2:0], trial_ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r && (rd_data_r != '0);
      unique case (state_r)
        S_IDLE: begin
          if (wr_en && job.emit) begin
            state_r <= S_SWEEP;
            issue_r <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (issue_r && kidx_rd_r == cfg.kk - 1'b1) issue_r <= 1'b0;
          if (!issue_r && !s1_v_r && !s2_v_r) state_r <= S_FIN;
        end
        S_FIN: begin
          if (centre_r != '0) begin
            state_r <= S_OUT;
          end else if (miss_r > MISS_W'(cfg.limit) || miss_r >= MISS_W'(ONE_Q16)) begin
            state_r <= S_OUT;   // too much missing: value stays zero
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_r == DCNT_W'(SUM_W)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/depth_hole_fill_normalized_conv.sv
// ----------------------------------------------------------------------------
// depth_hole_fill_normalized_conv
// Depth-image hole filling by normalized convolution over a KxK window.
// ----------------------------------------------------------------------------
// The front takes one word per cycle while the two-entry job queue has room
// and tracks the raster position. The back runs one job at a time: a weight
// load or a pixel whose window is not emitted only writes its store; an emitted
// pixel also reads its window from the line store one entry a cycle and then
// flushes the read pipe; a missing centre next runs a restoring divider, unless
// too much weight is missing, and the result waits in the output register
// until taken. The line store holds 5 rows of 2048 pixels and is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_hole_fill_normalized_conv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // pixel_value, weight_index, weight_value
  input  wire logic        in_tuser,   // operation
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_value, out_col, out_row
  output logic             out_tuser,  // was_filled
  output logic             out_tlast,  // frame_last
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata
);
  import dhf_pkg::*;

  logic [WCFG_W-1:0] width_r;
  logic [ROW_W-1:0]  height_r;
  logic [KS_W-1:0]   kernel_r;
  logic [WT_W-1:0]   limit_r;
  dhf_cfg_t          cfg;
  logic [KS_W-1:0]   k_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WCFG_W'(640);
      height_r <= ROW_W'(480);
      kernel_r <= KS_W'(5);
      limit_r  <= WT_W'(58982);
    end else if (cfg_we) begin
      unique case (dhf_reg_t'(cfg_addr))
        REG_WIDTH:  width_r  <= cfg_wdata[WCFG_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
        REG_KERNEL: kernel_r <= cfg_wdata[KS_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_wdata[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width = (width_r > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : width_r;
    if (cfg.width == '0) cfg.width = WCFG_W'(1);
    cfg.height = (height_r == '0) ? ROW_W'(1) : height_r;
    k_eff = (kernel_r > KS_W'(MAX_KERNEL)) ? KS_W'(MAX_KERNEL) : kernel_r;
    if (k_eff == '0) k_eff = KS_W'(1);
    if (!k_eff[0]) k_eff = k_eff - 1'b1;
    cfg.span  = k_eff - 1'b1;
    cfg.half  = k_eff >> 1;
    cfg.kk    = KK_W'(k_eff) * KK_W'(k_eff);
    cfg.limit = limit_r;
  end

  dhf_job_t push_job, head_job;
  logic     q_push, q_full, q_pop, q_not_empty;
  logic [PIXEL_BITS-1:0] o_value;
  logic [COL_W-1:0]      o_col;
  logic [ROW_W-1:0]      o_row;

  dhf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_pix   (in_tdata[15:0]),
    .in_widx  (in_tdata[20:16]),
    .in_wval  (in_tdata[37:21]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  dhf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_job  (head_job),
    .not_empty (q_not_empty)
  );

  dhf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .job        (head_job),
    .job_valid  (q_not_empty),
    .job_pop    (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (o_value),
    .out_col    (o_col),
    .out_row    (o_row),
    .out_filled (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b0, o_row, o_col, o_value};

  // no job leaves the queue while a word waits at the output
  a_no_pop_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !q_pop) else $error("job popped while output pending");

  // the frame end marker sits on the last interior position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (o_row == ROW_W'(cfg.height - ROW_W'(cfg.half) - 1'b1)) &&
      (o_col == COL_W'(cfg.width - WCFG_W'(cfg.half) - 1'b1)))
    else $error("frame end marker off position");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

`default_nettype wire

>>> sim/tb_depth_hole_fill_normalized_conv.sv
// ----------------------------------------------------------------------------
// tb_depth_hole_fill_normalized_conv
// Self-checking bench for the depth hole-fill block. A behavioral copy of the
// fill arithmetic predicts every result word; the bench sends kernel loads,
// whole and partial raster frames under many settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_depth_hole_fill_normalized_conv;
  import dhf_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE       = 120;
  localparam int RAND_PIXELS  = 1280;
  localparam int WIDE_PIXELS  = 40;

  typedef struct {
    logic [15:0] value;
    logic [10:0] col;
    logic [15:0] row;
    logic        filled;
    logic        last;
  } fill_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;  // pixel_value, weight_index, weight_value
  logic in_tuser = 1'b0;       // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;      // out_value, out_col, out_row
  logic out_tuser;             // was_filled
  logic out_tlast;             // frame_last
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [16:0] cfg_wdata = '0;

  depth_hole_fill_normalized_conv dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [11:0] img_width_reg = 12'd640;
  logic [15:0] img_height_reg = 16'd480;
  logic [2:0]  ksize_reg = 3'd5;
  logic [16:0] miss_limit_reg = 17'd58982;
  logic [15:0] line_mem [0:MAX_KERNEL*MAX_WIDTH-1];
  logic [16:0] kernel_wt [0:NUM_WEIGHTS-1];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  fill_word_t pending_fill[$];
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls
  int ready_run = 0;
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (no_gaps || $urandom_range(0, 99) < 60) begin
      out_tready <= 1'b1;
      ready_run <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b0;
      ready_run <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    fill_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fill.size() == 0) begin
        $error("result word with nothing expected: data %h", out_tdata);
        errors++;
      end else begin
        e = pending_fill.pop_front();
        if (out_tdata[15:0] !== e.value) begin
          $error("out_value expected %0d actual %0d", e.value, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[26:16] !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_tdata[26:16]);
          errors++;
        end
        if (out_tdata[42:27] !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_tdata[42:27]);
          errors++;
        end
        if (out_tuser !== e.filled) begin
          $error("was_filled expected %0d actual %0d", e.filled, out_tuser);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("frame_last expected %0d actual %0d", e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w = img_width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return (w == 0) ? 1 : w;
  endfunction

  function automatic int unsigned eff_height();
    return (img_height_reg == 0) ? 1 : img_height_reg;
  endfunction

  function automatic int unsigned eff_kernel();
    int unsigned k = ksize_reg;
    if (k > MAX_KERNEL) k = MAX_KERNEL;
    if (k == 0) k = 1;
    if (k % 2 == 0) k = k - 1;
    return k;
  endfunction

  // normalized convolution of one accepted word
  task automatic predict_fill(input dhf_op_t op, input logic [15:0] pix,
                              input logic [4:0] widx, input logic [16:0] wval);
    int unsigned w, h, k, span, half, col, row, slot, wt;
    longint unsigned acc, value;
    int unsigned missing;
    logic [15:0] win [0:NUM_WEIGHTS-1];
    fill_word_t r;
    w = eff_width();
    h = eff_height();
    k = eff_kernel();
    span = k - 1;
    half = k / 2;
    acc = 0;
    missing = 0;
    if (op == OP_WEIGHT) begin
      if (widx < NUM_WEIGHTS) kernel_wt[widx] = wval;
      return;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    line_mem[(row % MAX_KERNEL) * MAX_WIDTH + col] = pix;
    if (col >= span && row >= span) begin
      for (int dy = 0; dy < k; dy++) begin
        slot = (row - span + dy) % MAX_KERNEL;
        for (int dx = 0; dx < k; dx++)
          win[dx + dy * k] = line_mem[slot * MAX_WIDTH + col - span + dx];
      end
      r.filled = 1'b0;
      if (win[half + half * k] != 0) begin
        value = win[half + half * k];
      end else begin
        for (int i = 0; i < k * k; i++) begin
          wt = kernel_wt[i];
          if (win[i] != 0) acc += longint'(win[i]) * wt;
          else missing += wt;
        end
        if (missing > miss_limit_reg || missing >= ONE_Q16) begin
          value = 0;
        end else begin
          value = acc / (ONE_Q16 - missing);
          if (value > 65535) value = 65535;
          r.filled = 1'b1;
        end
      end
      r.value = value[15:0];
      r.col = 11'(col - half);
      r.row = 16'(row - half);
      r.last = (col == w - 1 && row == h - 1);
      pending_fill.push_back(r);
    end
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic send_word(input dhf_op_t op, input logic [15:0] pix,
                           input logic [4:0] widx, input logic [16:0] wval);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, wval, widx, pix};
    do @(posedge clk); while (!in_tready);
    predict_fill(op, pix, widx, wval);
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) >= 70)
      gap = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pixel(input logic [15:0] pix);
    send_word(OP_PIXEL, pix, 5'($urandom), 17'($urandom));
  endtask

  task automatic load_weight(input logic [4:0] widx, input logic [16:0] wval);
    send_word(OP_WEIGHT, 16'($urandom), widx, wval);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_fill.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input dhf_reg_t r, input logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      REG_WIDTH:  img_width_reg = v[11:0];
      REG_HEIGHT: img_height_reg = v[15:0];
      REG_KERNEL: ksize_reg = v[2:0];
      REG_LIMIT:  miss_limit_reg = v;
    endcase
  endtask

  task automatic set_geometry(input int w, input int h, input int k, input int lim);
    write_reg(REG_WIDTH, 17'(w));
    write_reg(REG_HEIGHT, 17'(h));
    write_reg(REG_KERNEL, 17'(k));
    write_reg(REG_LIMIT, 17'(lim));
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'd0;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one whole frame, sometimes with weight reloads in between
  task automatic send_frame(output int sent);
    int total;
    total = eff_width() * eff_height();
    sent = 0;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 19) == 0)
        load_weight(5'($urandom_range(0, 31)), 17'($urandom_range(0, 5000)));
      send_pixel(rand_pixel());
      sent++;
    end
  endtask

  task automatic test_weight_loads();
    load_weight(5'd31, 17'h1FFFF & 17'd65536);  // out of range, dropped
    load_weight(5'd25, 17'd0);
    for (int i = 0; i < NUM_WEIGHTS; i++) load_weight(5'(i), 17'd2621);
    load_weight(5'd12, 17'd65536);
    load_weight(5'd12, 17'd2621);
    drain();
  endtask

  task automatic test_small_frames();
    int n;
    set_geometry(4, 4, 4, 58982);       // even size steps down to three
    send_pixel(16'd0);
    send_pixel(16'hFFFF);
    send_pixel(16'd1);
    send_pixel(16'h8000);
    send_pixel(16'd0);
    send_pixel(16'd0);
    send_pixel(16'h7FFF);
    send_pixel(16'd0);
    for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
    drain();
    set_geometry(2, 4, 3, 0);           // too narrow for the window
    send_frame(n);
    drain();
    set_geometry(5, 5, 7, 65536);       // size above the maximum
    send_frame(n);
    drain();
  endtask

  task automatic test_zero_divisor();
    set_geometry(1, 2, 0, 65536);
    load_weight(5'd0, 17'd65536);
    send_pixel(16'd0);                  // missing weight reaches one
    send_pixel(16'd7);
    drain();
    load_weight(5'd0, 17'd0);
    send_pixel(16'd0);                  // nothing missing, quotient zero
    send_pixel(16'd0);
    drain();
    load_weight(5'd0, 17'd2621);
    drain();
  endtask

  task automatic test_wide_and_tall();
    no_gaps = 1;
    set_geometry(4095, 0, 1, 58982);    // width clamps, height zero is one row
    for (int i = 0; i < WIDE_PIXELS; i++) send_pixel(rand_pixel());
    drain();
    no_gaps = 0;
    set_geometry(0, 65535, 2, 58982);   // narrower width wraps the column
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    drain();
    write_reg(REG_HEIGHT, 17'd1);        // counters wrap back to the top
    send_pixel(16'd9);
    drain();
  endtask

  task automatic test_random_frames();
    int sent, n;
    int unsigned lim;
    sent = 0;
    while (sent < RAND_PIXELS) begin
      case ($urandom_range(0, 5))
        0:       lim = 0;
        1:       lim = 65536;
        2:       lim = $urandom_range(0, 65536);
        default: lim = 58982;
      endcase
      if ($urandom_range(0, 9) == 0)
        set_geometry($urandom_range(20, 60), $urandom_range(5, 7), $urandom_range(0, 7), lim);
      else
        set_geometry($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7), lim);
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < NUM_WEIGHTS; i++)
          load_weight(5'(i), ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 65536))
                                                         : 17'($urandom_range(0, 6000)));
      no_gaps = ($urandom_range(0, 4) == 0);
      send_frame(n);
      sent += n;
      drain();
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_weight_loads();
    test_small_frames();
    test_zero_divisor();
    test_wide_and_tall();
    test_random_frames();
    drain();
    if (errors == 0 && pending_fill.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> depth_hole_fill_normalized_conv.f
rtl/core/dhf_pkg.sv
rtl/core/dhf_fifo.sv
rtl/core/dhf_front.sv
rtl/core/dhf_back.sv
rtl/core/depth_hole_fill_normalized_conv.sv
sim/tb_depth_hole_fill_normalized_conv.sv
